/* hw/rtl/assert_macros.svh */
// assertion macros used by the sorted key table top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(label, expr, msg)
`define ASSERT_IMPLIES(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

/* hw/rtl/ksts_pkg.sv */
// types and codes for the sorted key table
package ksts_pkg;

    localparam int KEY_W     = 32;
    localparam int ACTION_W  = 2;
    localparam int STATUS_W  = 2;
    localparam int ENTRIES_W = 7;

    typedef logic signed [KEY_W-1:0] key_t;

    localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_REDUCE,
        S_APPLY
    } fsm_state_t;

    // control broadcast to every cell
    typedef struct packed {
        logic cmp_en;
        logic shift_up;
        logic shift_down;
    } cell_ctl_t;

endpackage

/* hw/rtl/ksts_cell.sv */
// one slot of the sorted key chain: stored key, compare flags, shift mux
module ksts_cell
    import ksts_pkg::*;
(
    input  logic      clk,
    input  cell_ctl_t ctl,
    input  key_t      op_key,
    input  logic      valid,
    input  key_t      left_key,
    input  logic      left_le,
    input  key_t      right_key,
    output key_t      key_q,
    output logic      le_q,
    output logic      eq_q
);

    key_t key_reg;
    key_t key_next;
    logic le_reg;
    logic lt_reg;
    logic eq_reg;

    // flags are captured once per item and held while the item runs
    always_ff @(posedge clk)
    begin
        if (ctl.cmp_en)
        begin
            le_reg <= valid && (key_reg <= op_key);
            lt_reg <= valid && (key_reg < op_key);
            eq_reg <= valid && (key_reg == op_key);
        end
        key_reg <= key_next;
    end

    always_comb
    begin
        key_next = key_reg;
        if (ctl.shift_up && !le_reg)
        begin
            // insertion point takes the new key, cells above it move up
            key_next = left_le ? op_key : left_key;
        end
        else if (ctl.shift_down && !lt_reg)
        begin
            // removed slot and everything above it move down
            key_next = right_key;
        end
    end

    assign key_q = key_reg;
    assign le_q  = le_reg;
    assign eq_q  = eq_reg;

endmodule

/* hw/rtl/ksts_or_tree.sv */
// registered binary or-reduction over the per-cell match flags
module ksts_or_tree #(
    parameter int LEAVES = 64
) (
    input  logic              clk,
    input  logic [LEAVES-1:0] leaves,
    output logic              any
);

    localparam int LVL = (LEAVES > 1) ? $clog2(LEAVES) : 1;
    localparam int PAD = 1 << LVL;

    logic [PAD-1:1]   node_reg;
    logic [PAD-1:1]   node_next;
    logic [2*PAD-1:1] heap;

    // heap layout: root at 1, leaves at PAD .. 2*PAD-1
    always_comb
    begin
        heap = '0;
        for (int j = 1; j < PAD; j++)
        begin
            heap[j] = node_reg[j];
        end
        for (int i = 0; i < LEAVES; i++)
        begin
            heap[PAD + i] = leaves[i];
        end
        for (int j = 1; j < PAD; j++)
        begin
            node_next[j] = heap[2*j] | heap[2*j + 1];
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg <= node_next;
    end

    assign any = node_reg[1];

endmodule

/* hw/rtl/sorted_key_table_search_top.sv */
// sorted key table: chain of key cells with add, remove and lookup
//
// channel  direction  handshake            payload
// in       to block   in_valid / in_stall  action[1:0], key[31:0] signed
// out      from block out_valid / out_stall found, status[1:0], entries[6:0]
//
// an add or an unused action runs through the compare and update states; a
// remove or lookup also runs through the reduce state, whose length is set by
// the depth of the registered or-tree that collects the per-cell match flags
// reset clears the entry count and the control state; the key cells hold no
// reset value and need no clearing pass, since only cells below the count
// take part in a compare
// a new item is taken while a finished result waits; a stalled output holds
// the block in its update cycle until the waiting result is taken
module sorted_key_table_search_top
    import ksts_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [ACTION_W-1:0]  action,
    input  key_t                 key,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 found,
    output logic [STATUS_W-1:0]  status,
    output logic [ENTRIES_W-1:0] entries
);

`include "assert_macros.svh"

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int LVL   = $clog2(CAPACITY);
    localparam int RCW   = $clog2(LVL + 1);

    // control state
    fsm_state_t       state_reg;
    fsm_state_t       state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [RCW-1:0]   red_cnt_reg;
    logic [RCW-1:0]   red_cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    // latched item and result payload
    logic [ACTION_W-1:0]  op_action_reg;
    key_t                 op_key_reg;
    logic                 found_reg;
    logic                 found_next;
    logic [STATUS_W-1:0]  status_reg;
    logic [STATUS_W-1:0]  status_next;
    logic [ENTRIES_W-1:0] entries_reg;
    logic [ENTRIES_W-1:0] entries_next;

    // chain wiring
    cell_ctl_t             ctl;
    key_t                  cell_key [CAPACITY];
    logic [CAPACITY-1:0]   cell_le;
    logic [CAPACITY-1:0]   cell_eq;
    logic [CAPACITY-1:0]   cell_valid;
    logic                  hit;
    logic                  in_take;
    logic                  out_take;
    logic                  apply_en;
    logic                  is_add;
    logic                  is_rem;
    logic                  is_look;
    logic                  full;
    logic                  le_prefix_ok;

    assign in_take  = in_valid && !in_stall;
    assign out_take = out_valid_reg && !out_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign apply_en = (state_reg == S_APPLY) && (!out_valid_reg || !out_stall);

    assign is_add  = (op_action_reg == ACT_ADD);
    assign is_rem  = (op_action_reg == ACT_REMOVE);
    assign is_look = (op_action_reg == ACT_LOOKUP);
    assign full    = (count_reg == CNT_W'(CAPACITY));

    // ---------------------------------------------------------------
    // cell chain: cell i holds the i-th smallest key while i < count
    // ---------------------------------------------------------------
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        key_t left_key;
        logic left_le;
        key_t right_key;

        assign cell_valid[i] = (count_reg > CNT_W'(i));

        if (i == 0)
        begin : g_first
            // nothing to the left: the bottom cell is the insertion point
            // whenever its own key is above the new key
            assign left_key = op_key_reg;
            assign left_le  = 1'b1;
        end
        else
        begin : g_mid
            assign left_key = cell_key[i-1];
            assign left_le  = cell_le[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_key = cell_key[i];
        end
        else
        begin : g_below
            assign right_key = cell_key[i+1];
        end

        ksts_cell u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .op_key    (op_key_reg),
            .valid     (cell_valid[i]),
            .left_key  (left_key),
            .left_le   (left_le),
            .right_key (right_key),
            .key_q     (cell_key[i]),
            .le_q      (cell_le[i]),
            .eq_q      (cell_eq[i])
        );
    end

    // any valid cell equal to the key, collected by the registered or-tree
    ksts_or_tree #(
        .LEAVES (CAPACITY)
    ) u_or_tree (
        .clk    (clk),
        .leaves (cell_eq),
        .any    (hit)
    );

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            red_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            red_cnt_reg   <= red_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_action_reg <= action;
            op_key_reg    <= key;
        end
        if (apply_en)
        begin
            found_reg   <= found_next;
            status_reg  <= status_next;
            entries_reg <= entries_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        red_cnt_next   = red_cnt_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        ctl            = '0;
        found_next     = 1'b0;
        status_next    = ST_DONE;

        if (out_take)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                ctl.cmp_en   = 1'b1;
                red_cnt_next = '0;
                // add and the unused code need no match search
                if (is_rem || is_look)
                begin
                    state_next = S_REDUCE;
                end
                else
                begin
                    state_next = S_APPLY;
                end
            end
            S_REDUCE:
            begin
                if (red_cnt_reg == RCW'(LVL - 1))
                begin
                    state_next = S_APPLY;
                end
                else
                begin
                    red_cnt_next = red_cnt_reg + 1'b1;
                end
            end
            S_APPLY:
            begin
                if (is_add)
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        count_next = apply_en ? count_reg + 1'b1 : count_reg;
                    end
                end
                else if (is_rem)
                begin
                    if (hit)
                    begin
                        count_next = apply_en ? count_reg - 1'b1 : count_reg;
                    end
                    else
                    begin
                        status_next = ST_ABSENT;
                    end
                end
                else if (is_look)
                begin
                    found_next = hit;
                end

                ctl.shift_up   = apply_en && is_add && !full;
                ctl.shift_down = apply_en && is_rem && hit;

                if (apply_en)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // entries wraps modulo 128 for large tables
    assign entries_next = ENTRIES_W'(count_next);

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign status    = status_reg;
    assign entries   = entries_reg;

    // a sorted chain gives a prefix of cells at or below the key
    assign le_prefix_ok = (((cell_le >> 1) & ~cell_le) == '0);

    `ASSERT_ALWAYS(a_count_range, count_reg <= CNT_W'(CAPACITY), "entry count above capacity")
    `ASSERT_IMPLIES(a_le_prefix, state_reg == S_APPLY, le_prefix_ok, "key chain out of order")
    `ASSERT_NEXT(a_count_hold, !apply_en, count_reg == $past(count_reg), "count moved outside update")
    `ASSERT_IMPLIES(a_out_source, $rose(out_valid_reg), $past(state_reg == S_APPLY), "result without update")

endmodule

/* tb/tb_sorted_key_table_search_top.sv */
// self-checking testbench for the sorted key table: directed rows, then random add/remove/lookup
module tb_sorted_key_table_search_top
    import ksts_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // block size and run pacing
    localparam int CAP             = 64;
    localparam int HALF_PERIOD     = 10;
    localparam int RESET_CYCLES    = 12;
    localparam int RANDOM_ITEMS    = 1650;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 20;
    // cycle limit for the whole run, enforced by the watchdog
    localparam int LIMIT_CYCLES    = 400000;

    // action code that the block treats as a no-op
    localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

    // one result of the block, in port order
    typedef struct packed {
        logic                 found;
        logic [STATUS_W-1:0]  status;
        logic [ENTRIES_W-1:0] entries;
    } table_reply_t;

    // one directed row: the item, and a typed-in result where it is obvious
    typedef struct packed {
        logic [ACTION_W-1:0] act;
        key_t                k;
        logic                typed;
        table_reply_t        want;
    } probe_row_t;

    // operation mix of one random burst
    typedef enum logic [1:0] {
        MIX_FILL,
        MIX_EVEN,
        MIX_DRAIN
    } mix_t;

    localparam int DIR_N = 24;

    // walk from an empty table through extremes, duplicates and absent-key refusals
    localparam probe_row_t DIRECTED_ROWS [DIR_N] = '{
        // lookup in an empty table
        '{ACT_LOOKUP, 32'sd0,            1'b1, '{1'b0, ST_DONE,   7'd0}},
        // remove from an empty table
        '{ACT_REMOVE, 32'sd5,            1'b1, '{1'b0, ST_ABSENT, 7'd0}},
        // unused action code leaves everything alone
        '{ACT_NONE,   -32'sd1,           1'b1, '{1'b0, ST_DONE,   7'd0}},
        // both key extremes
        '{ACT_ADD,    32'sh7FFF_FFFF,    1'b1, '{1'b0, ST_DONE,   7'd1}},
        '{ACT_ADD,    32'sh8000_0000,    1'b1, '{1'b0, ST_DONE,   7'd2}},
        // a duplicate pair around zero
        '{ACT_ADD,    32'sd0,            1'b0, '0},
        '{ACT_ADD,    32'sd0,            1'b0, '0},
        '{ACT_ADD,    -32'sd1,           1'b0, '0},
        '{ACT_ADD,    32'sd1,            1'b0, '0},
        '{ACT_LOOKUP, 32'sh8000_0000,    1'b0, '0},
        '{ACT_LOOKUP, 32'sh7FFF_FFFF,    1'b0, '0},
        '{ACT_LOOKUP, 32'sd2,            1'b0, '0},
        '{ACT_LOOKUP, 32'sh7FFF_FFFE,    1'b0, '0},
        // removing one copy keeps the other
        '{ACT_REMOVE, 32'sd0,            1'b0, '0},
        '{ACT_LOOKUP, 32'sd0,            1'b0, '0},
        '{ACT_REMOVE, 32'sd0,            1'b0, '0},
        '{ACT_LOOKUP, 32'sd0,            1'b0, '0},
        '{ACT_REMOVE, 32'sd0,            1'b0, '0},
        '{ACT_NONE,   32'sh5555_5555,    1'b0, '0},
        '{ACT_REMOVE, 32'sh8000_0000,    1'b0, '0},
        '{ACT_REMOVE, 32'sh7FFF_FFFF,    1'b0, '0},
        '{ACT_NONE,   32'shAAAA_AAAA,    1'b0, '0},
        '{ACT_REMOVE, -32'sd1,           1'b0, '0},
        '{ACT_REMOVE, 32'sd1,            1'b0, '0}
    };

    // corner keys that random items draw from now and then
    localparam key_t KEY_CORNERS [6] = '{
        32'sh8000_0000, 32'sh8000_0001, 32'sh7FFF_FFFF, 32'sh7FFF_FFFE, 32'sd0, -32'sd1
    };

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [ACTION_W-1:0]  action;
    key_t                 key;
    logic                 out_valid;
    logic                 out_stall;
    logic                 found;
    logic [STATUS_W-1:0]  status;
    logic [ENTRIES_W-1:0] entries;

    // predictor state: sorted copy of the table
    key_t held_keys [CAP];
    int   held = 0;

    // results still owed by the block, oldest first
    table_reply_t reply_queue [$];

    // pacing knobs, percent of cycles spent idle on each side
    int tx_idle_pct   = 6;
    int rx_idle_pct   = 78;
    bit hold_off_req  = 1'b0;

    int fail_cnt      = 0;
    int cycle_cnt     = 0;

    // run statistics for the summary
    int n_add = 0, n_full = 0, n_remove = 0, n_absent = 0, n_lookup = 0, n_hit = 0;
    int n_noop = 0, peak = 0;

    sorted_key_table_search_top #(
        .CAPACITY (CAP)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .key       (key),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .found     (found),
        .status    (status),
        .entries   (entries)
    );

    always #HALF_PERIOD clk = ~clk;

    // apply one operation to the predicted table and return the result it gives
    function automatic table_reply_t apply_op(input logic [ACTION_W-1:0] act, input key_t k);
        table_reply_t r;
        int           pos;
        int           i;
        r   = '0;
        pos = 0;
        case (act)
            ACT_ADD:
            begin
                if (held >= CAP)
                    r.status = ST_FULL;
                else
                begin
                    // new key goes after any equal keys
                    while (pos < held && held_keys[pos] <= k)
                        pos++;
                    for (i = held; i > pos; i--)
                        held_keys[i] = held_keys[i - 1];
                    held_keys[pos] = k;
                    held++;
                end
            end
            ACT_REMOVE:
            begin
                while (pos < held && held_keys[pos] < k)
                    pos++;
                if (pos < held && held_keys[pos] == k)
                begin
                    for (i = pos; i + 1 < held; i++)
                        held_keys[i] = held_keys[i + 1];
                    held--;
                end
                else
                    r.status = ST_ABSENT;
            end
            ACT_LOOKUP:
            begin
                while (pos < held && held_keys[pos] < k)
                    pos++;
                r.found = (pos < held && held_keys[pos] == k);
            end
            default:
            begin
            end
        endcase
        r.entries = ENTRIES_W'(held);
        return r;
    endfunction

    // key for a random item: often one already held, else pool, corners, neighbors, noise
    function automatic key_t pick_key(input bit from_table);
        int r;
        r = $urandom_range(99);
        if (from_table && held > 0 && r < 75)
            return held_keys[$urandom_range(held - 1)];
        r = $urandom_range(99);
        if (r < 35)
            return key_t'(int'($urandom_range(15)) - 8);
        if (r < 50)
            return KEY_CORNERS[$urandom_range(5)];
        if (r < 65 && held > 0)
            return held_keys[$urandom_range(held - 1)] + key_t'(int'($urandom_range(1)) * 2 - 1);
        return key_t'($urandom);
    endfunction

    // offer one item, wait for acceptance, then log what the block owes for it
    task automatic offer_item(input logic [ACTION_W-1:0] act, input key_t k,
                              input logic typed, input table_reply_t want);
        table_reply_t got;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        key      <= k;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        got = apply_op(act, k);
        reply_queue.insert(reply_queue.size(), typed ? want : got);
        case (act)
            ACT_ADD:
            begin
                n_add++;
                n_full += (got.status == ST_FULL);
            end
            ACT_REMOVE:
            begin
                n_remove++;
                n_absent += (got.status == ST_ABSENT);
            end
            ACT_LOOKUP:
            begin
                n_lookup++;
                n_hit += got.found;
            end
            default:
                n_noop++;
        endcase
        if (held > peak)
            peak = held;
    endtask

    // receiver pacing, with one long hold-off once the sender stops idling
    initial
    begin : rx_pace
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                // block fills up and must stall the sender
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES)
                    @(posedge clk);
                hold_off_req = 1'b0;
                out_stall <= 1'b0;
            end
            else
                out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // compare each accepted result with the oldest one owed
    always @(posedge clk)
    begin : reply_check
        table_reply_t want;
        if (out_valid && !out_stall)
        begin
            if (reply_queue.size() == 0)
            begin
                $error("result with nothing owed: found %0d status %0d entries %0d",
                       found, status, entries);
                fail_cnt++;
            end
            else
            begin
                want = reply_queue.pop_front();
                if (found !== want.found)
                begin
                    $error("found: expected %0d, got %0d", want.found, found);
                    fail_cnt++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    fail_cnt++;
                end
                if (entries !== want.entries)
                begin
                    $error("entries: expected %0d, got %0d", want.entries, entries);
                    fail_cnt++;
                end
            end
        end
    end

    // watchdog
    initial
    begin : watchdog
        while (cycle_cnt < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d results still owed",
                 cycle_cnt, reply_queue.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : stimulus
        int   n_items;
        int   burst_left;
        int   r;
        mix_t mix;
        logic [ACTION_W-1:0] act;

        rst_n    = 1'b0;
        in_valid = 1'b0;
        action   = ACT_ADD;
        key      = '0;

        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows, paced like the first random phase
        for (int i = 0; i < DIR_N; i++)
            offer_item(DIRECTED_ROWS[i].act, DIRECTED_ROWS[i].k,
                       DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

        // random bursts; the first one fills the table so adds hit the full case early
        n_items    = 0;
        mix        = MIX_FILL;
        burst_left = 100;
        while (n_items < RANDOM_ITEMS)
        begin
            // pacing phases: slow receiver, then slow sender, then full speed
            if (n_items >= 2 * RANDOM_ITEMS / 3 && tx_idle_pct != 0)
            begin
                tx_idle_pct  = 0;
                rx_idle_pct  = 0;
                hold_off_req = 1'b1;
            end
            else if (n_items >= RANDOM_ITEMS / 3 && tx_idle_pct == 6)
            begin
                tx_idle_pct = 78;
                rx_idle_pct = 6;
            end

            if (burst_left == 0)
            begin
                burst_left = $urandom_range(60, 140);
                mix        = mix_t'($urandom_range(2));
            end
            burst_left--;

            r = $urandom_range(99);
            case (mix)
                MIX_FILL:
                    act = (r < 80) ? ACT_ADD : (r < 88) ? ACT_LOOKUP :
                          (r < 95) ? ACT_REMOVE : ACT_NONE;
                MIX_DRAIN:
                    act = (r < 10) ? ACT_ADD : (r < 72) ? ACT_REMOVE :
                          (r < 96) ? ACT_LOOKUP : ACT_NONE;
                default:
                    act = (r < 38) ? ACT_ADD : (r < 70) ? ACT_REMOVE :
                          (r < 96) ? ACT_LOOKUP : ACT_NONE;
            endcase

            offer_item(act, pick_key(act == ACT_REMOVE || act == ACT_LOOKUP), 1'b0, '0);
            n_items++;
        end
        in_valid <= 1'b0;

        // drain everything owed, then let the block settle
        while (reply_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        $display("ran %0d adds (%0d refused when full), %0d removes (%0d of absent keys),",
                 n_add, n_full, n_remove, n_absent);
        $display("%0d lookups (%0d hits) and %0d no-ops; table peaked at %0d of %0d keys",
                 n_lookup, n_hit, n_noop, peak, CAP);
        if (fail_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
